### design/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg: shared types and constants of the stepper ramp step generator
// Holds the command codes, field widths and the acceleration ramp table.
// ----------------------------------------------------------------------------
`default_nettype none

package srsg_pkg;

   // Field widths.
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned WAIT_W   = 22;
   localparam int unsigned DELAY_W  = 16;
   localparam int unsigned THRESH_W = 13;

   // Ramp table geometry.
   localparam int unsigned ROM_SIZE = 28;
   localparam int unsigned RIDX_W   = 5;

   // Reset value of the homing delay register.
   localparam logic [DELAY_W-1:0] HOME_DELAY_RESET = 16'd150;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_SET_TARGET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE_STEP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME_TICK  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE       = 2'd3;

   // One ramp table entry: step count at which it applies and its delay.
   typedef struct packed {
      logic [THRESH_W-1:0] thresh;
      logic [WAIT_W-1:0]   delay;
   } ramp_entry_type;

   // Acceleration ramp table, indexed by the ramp position.
   function automatic ramp_entry_type ramp_rom(input logic [RIDX_W-1:0] idx);
      ramp_entry_type e;
      case (idx)
         5'd0:    e = '{13'd0,    22'd2577320};
         5'd1:    e = '{13'd1,    22'd55432};
         5'd2:    e = '{13'd3,    22'd8013};
         5'd3:    e = '{13'd7,    22'd4132};
         5'd4:    e = '{13'd14,   22'd2392};
         5'd5:    e = '{13'd24,   22'd1502};
         5'd6:    e = '{13'd40,   22'd1006};
         5'd7:    e = '{13'd62,   22'd708};
         5'd8:    e = '{13'd92,   22'd521};
         5'd9:    e = '{13'd183,  22'd172};
         5'd10:   e = '{13'd289,  22'd147};
         5'd11:   e = '{13'd412,  22'd128};
         5'd12:   e = '{13'd551,  22'd112};
         5'd13:   e = '{13'd707,  22'd100};
         5'd14:   e = '{13'd880,  22'd90};
         5'd15:   e = '{13'd1071, 22'd82};
         5'd16:   e = '{13'd1277, 22'd76};
         5'd17:   e = '{13'd1499, 22'd70};
         5'd18:   e = '{13'd1736, 22'd66};
         5'd19:   e = '{13'd1986, 22'd63};
         5'd20:   e = '{13'd2260, 22'd57};
         5'd21:   e = '{13'd2542, 22'd55};
         5'd22:   e = '{13'd2831, 22'd54};
         5'd23:   e = '{13'd3129, 22'd53};
         5'd24:   e = '{13'd3432, 22'd52};
         5'd25:   e = '{13'd3738, 22'd51};
         5'd26:   e = '{13'd4047, 22'd50};
         5'd27:   e = '{13'd4669, 22'd50};
         default: e = '{'0, '0};
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### design/stepper_ramp_step_generator_top.sv
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_top: two-axis stepper step generator
// Decides one step per command beat, with an acceleration ramp for moves and
// a fixed-delay homing sequence.
// ----------------------------------------------------------------------------
// A command beat passes the input register and then the result register, whose
// valid bit drives rsp_valid for the result beat.
// Throughput: one command beat per cycle; busy stays low, since the state
// update for one beat fits between the input register and the result register.
// Reset: synchronous, active high; clears positions, targets, the ramp and the
// homing delay (back to 150 us). The receiver cannot stall the result strobe.
`default_nettype none

module stepper_ramp_step_generator_top #(
   parameter int unsigned RAMP_ENTRIES = 28
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Command channel.
   input  wire                                 start,
   output logic                                busy,
   input  wire  [srsg_pkg::CMD_W-1:0]          req_cmd,
   input  wire                                 req_axis,
   input  wire  signed [srsg_pkg::POS_W-1:0]   req_target,
   input  wire                                 req_home_sense,
   // Configuration register.
   input  wire                                 csr_wr_en,
   input  wire  [srsg_pkg::DELAY_W-1:0]        csr_wr_data,
   // Result channel.
   output logic                                rsp_valid,
   output logic                                rsp_pulse,
   output logic                                rsp_dir_level,
   output logic [srsg_pkg::WAIT_W-1:0]         rsp_wait_us,
   output logic signed [srsg_pkg::POS_W-1:0]   rsp_position,
   output logic                                rsp_done_res
);

   // Number of ramp entries in use, capped at the table size.
   localparam int unsigned RAMP_LIMIT_I =
      (RAMP_ENTRIES < srsg_pkg::ROM_SIZE) ? RAMP_ENTRIES : srsg_pkg::ROM_SIZE;
   localparam logic [srsg_pkg::RIDX_W-1:0] RAMP_LIMIT = RAMP_LIMIT_I[srsg_pkg::RIDX_W-1:0];

   localparam int unsigned PW = srsg_pkg::POS_W;
   localparam int unsigned WW = srsg_pkg::WAIT_W;

   // Input register.
   logic                        in_valid_ff;
   logic [srsg_pkg::CMD_W-1:0]  cmd_ff;
   logic                        axis_ff;
   logic [PW-1:0]               target_ff;
   logic                        sense_ff;

   // Block state.
   logic [srsg_pkg::DELAY_W-1:0] home_delay_ff;
   logic [PW-1:0]                pos_ff [2];
   logic [PW-1:0]                tgt_ff [2];
   logic [PW-1:0]                step_cnt_ff, step_cnt_in;
   logic [srsg_pkg::RIDX_W-1:0]  ramp_idx_ff, ramp_idx_in;
   logic [WW-1:0]                cur_wait_ff, cur_wait_in;
   logic [PW-1:0]                pos_in, tgt_in;

   // Result register.
   logic          rsp_valid_ff;
   logic          pulse_ff, pulse_in;
   logic          dir_ff, dir_in;
   logic [WW-1:0] wait_ff, wait_in;
   logic [PW-1:0] position_ff;
   logic          done_ff, done_in;

   // Working values for the selected axis.
   logic [PW-1:0]            cur_pos;
   logic [PW-1:0]            cur_tgt;
   logic                     at_target;
   logic                     go_up;
   logic [PW-1:0]            stepped_pos;
   srsg_pkg::ramp_entry_type ramp_entry;
   logic                     ramp_hit;

   assign busy = 1'b0;

   // Capture the command beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      cmd_ff    <= req_cmd;
      axis_ff   <= req_axis;
      target_ff <= req_target;
      sense_ff  <= req_home_sense;
   end

   // Homing delay register.
   always_ff @(posedge clock) begin
      if (reset) begin
         home_delay_ff <= srsg_pkg::HOME_DELAY_RESET;
      end else if (csr_wr_en) begin
         home_delay_ff <= csr_wr_data;
      end
   end

   // Selected axis, direction and ramp table lookup.
   always_comb begin
      cur_pos     = pos_ff[axis_ff];
      cur_tgt     = tgt_ff[axis_ff];
      at_target   = (cur_pos == cur_tgt);
      go_up       = ($signed(cur_tgt) > $signed(cur_pos));
      stepped_pos = go_up ? (cur_pos + {{(PW-1){1'b0}}, 1'b1})
                          : (cur_pos - {{(PW-1){1'b0}}, 1'b1});
      ramp_entry  = srsg_pkg::ramp_rom(ramp_idx_ff);
      ramp_hit    = (ramp_idx_ff < RAMP_LIMIT) &&
                    (step_cnt_ff == {{(PW-srsg_pkg::THRESH_W){1'b0}}, ramp_entry.thresh});
   end

   // Next state and result for the registered command.
   always_comb begin
      step_cnt_in = step_cnt_ff;
      ramp_idx_in = ramp_idx_ff;
      cur_wait_in = cur_wait_ff;
      pos_in      = cur_pos;
      tgt_in      = cur_tgt;
      pulse_in    = 1'b0;
      dir_in      = 1'b0;
      wait_in     = '0;
      done_in     = at_target;
      case (cmd_ff)
         srsg_pkg::CMD_SET_TARGET: begin
            tgt_in      = target_ff;
            step_cnt_in = '0;
            ramp_idx_in = '0;
            done_in     = (cur_pos == target_ff);
         end
         srsg_pkg::CMD_MOVE_STEP: begin
            if (!at_target) begin
               if (ramp_hit) begin
                  cur_wait_in = ramp_entry.delay;
                  ramp_idx_in = ramp_idx_ff + {{(srsg_pkg::RIDX_W-1){1'b0}}, 1'b1};
               end
               if (step_cnt_ff != {PW{1'b1}}) begin
                  step_cnt_in = step_cnt_ff + {{(PW-1){1'b0}}, 1'b1};
               end
               pos_in   = stepped_pos;
               pulse_in = 1'b1;
               // Pin polarity is inverted on the y axis.
               dir_in   = go_up ^ axis_ff;
               wait_in  = cur_wait_in;
               done_in  = (stepped_pos == cur_tgt);
            end
         end
         srsg_pkg::CMD_HOME_TICK: begin
            if (sense_ff) begin
               pos_in  = '0;
               tgt_in  = '0;
               done_in = 1'b1;
            end else begin
               // Homing moves negative: x pin low, y pin high.
               pulse_in = 1'b1;
               dir_in   = axis_ff;
               wait_in  = {{(WW-srsg_pkg::DELAY_W){1'b0}}, home_delay_ff};
               done_in  = 1'b0;
            end
         end
         default: begin
            done_in = at_target;
         end
      endcase
   end

   // State update, taken only for a valid registered beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0]   <= '0;
         pos_ff[1]   <= '0;
         tgt_ff[0]   <= '0;
         tgt_ff[1]   <= '0;
         step_cnt_ff <= '0;
         ramp_idx_ff <= '0;
         cur_wait_ff <= '0;
      end else if (in_valid_ff) begin
         pos_ff[axis_ff] <= pos_in;
         tgt_ff[axis_ff] <= tgt_in;
         step_cnt_ff     <= step_cnt_in;
         ramp_idx_ff     <= ramp_idx_in;
         cur_wait_ff     <= cur_wait_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
      pulse_ff    <= pulse_in;
      dir_ff      <= dir_in;
      wait_ff     <= wait_in;
      position_ff <= pos_in;
      done_ff     <= done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pulse     = pulse_ff;
   assign rsp_dir_level = dir_ff;
   assign rsp_wait_us   = wait_ff;
   assign rsp_position  = position_ff;
   assign rsp_done_res  = done_ff;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the stepper ramp step generator
// Drives command beats with random gaps and compares every result beat with
// a cycle-free predictor of positions, targets, the shared acceleration ramp
// and the homing delay register. Covers directed corner cases, homing delay
// settings, a move long enough to climb several ramp entries, and random
// move and homing sequences with noise in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int RAMP_LEN    = 28;
   localparam int STALL_LIMIT = 1000;

   // One result beat as the block reports it.
   typedef struct {
      logic                              pulse;
      logic                              dir_level;
      logic [srsg_pkg::WAIT_W-1:0]       wait_us;
      logic signed [srsg_pkg::POS_W-1:0] position;
      logic                              done_res;
   } step_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [srsg_pkg::CMD_W-1:0]        req_cmd = srsg_pkg::CMD_NONE;
   logic                              req_axis = 1'b0;
   logic signed [srsg_pkg::POS_W-1:0] req_target = '0;
   logic                              req_home_sense = 1'b0;
   logic                              csr_wr_en = 1'b0;
   logic [srsg_pkg::DELAY_W-1:0]      csr_wr_data = '0;
   logic                              rsp_valid;
   logic                              rsp_pulse;
   logic                              rsp_dir_level;
   logic [srsg_pkg::WAIT_W-1:0]       rsp_wait_us;
   logic signed [srsg_pkg::POS_W-1:0] rsp_position;
   logic                              rsp_done_res;

   // Acceleration ramp: step count at which each entry applies, and its delay.
   int unsigned ramp_thresh [RAMP_LEN] = '{
      0, 1, 3, 7, 14, 24, 40, 62, 92, 183, 289, 412, 551, 707, 880, 1071,
      1277, 1499, 1736, 1986, 2260, 2542, 2831, 3129, 3432, 3738, 4047, 4669};
   int unsigned ramp_delay [RAMP_LEN] = '{
      2577320, 55432, 8013, 4132, 2392, 1502, 1006, 708, 521, 172, 147, 128,
      112, 100, 90, 82, 76, 70, 66, 63, 57, 55, 54, 53, 52, 51, 50, 50};

   // Predicted state of the step generator.
   logic signed [srsg_pkg::POS_W-1:0] axis_pos [2];
   logic signed [srsg_pkg::POS_W-1:0] axis_tgt [2];
   logic [srsg_pkg::POS_W-1:0]        move_cnt;
   int unsigned                       ramp_pos;
   logic [srsg_pkg::WAIT_W-1:0]       cur_wait;
   logic [srsg_pkg::DELAY_W-1:0]      home_delay;

   step_result_type pending_steps [$];
   int              mismatch_cnt = 0;
   int              beats_sent = 0;
   int              quiet_cycles = 0;
   bit              idle_on = 1'b0;

   stepper_ramp_step_generator_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_axis       (req_axis),
      .req_target     (req_target),
      .req_home_sense (req_home_sense),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_pulse      (rsp_pulse),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_wait_us    (rsp_wait_us),
      .rsp_position   (rsp_position),
      .rsp_done_res   (rsp_done_res)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Returns one random bit.
   function automatic logic rand_bit();
      int unsigned r;
      r = $urandom();
      return r[0];
   endfunction

   // Applies one command beat to the predicted state and returns its result.
   function automatic step_result_type compute_step(
         input logic [srsg_pkg::CMD_W-1:0]        cmd,
         input logic                              ax,
         input logic signed [srsg_pkg::POS_W-1:0] tgt,
         input logic                              sense);
      step_result_type r;
      logic            up;
      r.pulse     = 1'b0;
      r.dir_level = 1'b0;
      r.wait_us   = '0;
      r.done_res  = 1'b0;
      case (cmd)
         srsg_pkg::CMD_SET_TARGET: begin
            axis_tgt[ax] = tgt;
            move_cnt     = '0;
            ramp_pos     = 0;
            r.done_res   = (axis_pos[ax] == axis_tgt[ax]);
         end
         srsg_pkg::CMD_MOVE_STEP: begin
            if (axis_pos[ax] == axis_tgt[ax]) begin
               r.done_res = 1'b1;
            end else begin
               up = (axis_tgt[ax] > axis_pos[ax]);
               // The ramp advances when the step count meets the next threshold.
               if (ramp_pos < RAMP_LEN && move_cnt == ramp_thresh[ramp_pos]) begin
                  cur_wait = ramp_delay[ramp_pos][srsg_pkg::WAIT_W-1:0];
                  ramp_pos++;
               end
               if (move_cnt != '1) begin
                  move_cnt++;
               end
               axis_pos[ax] = up ? axis_pos[ax] + 1 : axis_pos[ax] - 1;
               r.pulse      = 1'b1;
               r.dir_level  = (ax == 1'b0) ? up : ~up;
               r.wait_us    = cur_wait;
               r.done_res   = (axis_pos[ax] == axis_tgt[ax]);
            end
         end
         srsg_pkg::CMD_HOME_TICK: begin
            if (sense) begin
               axis_pos[ax] = '0;
               axis_tgt[ax] = '0;
               r.done_res   = 1'b1;
            end else begin
               // Homing always steps negative: x pin low, y pin high.
               r.pulse     = 1'b1;
               r.dir_level = ax;
               r.wait_us   = {{(srsg_pkg::WAIT_W-srsg_pkg::DELAY_W){1'b0}}, home_delay};
            end
         end
         default: begin
            r.done_res = (axis_pos[ax] == axis_tgt[ax]);
         end
      endcase
      r.position = axis_pos[ax];
      return r;
   endfunction

   // Sends one command beat, with an optional idle burst ahead of it.
   task automatic send_cmd(input logic [srsg_pkg::CMD_W-1:0] cmd, input logic ax,
                           input logic [srsg_pkg::POS_W-1:0] tgt, input logic sense);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_axis       <= ax;
      req_target     <= tgt;
      req_home_sense <= sense;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_steps.push_back(compute_step(cmd, ax, tgt, sense));
      beats_sent++;
   endtask

   // Stops sending and waits until every expected result beat has arrived.
   task automatic settle_block();
      start <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_home_delay(input logic [srsg_pkg::DELAY_W-1:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      home_delay  = value;
   endtask

   // Reports one field mismatch.
   function automatic void check_field(input string name,
                                       input logic signed [63:0] expected,
                                       input logic signed [63:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_cnt++;
      end
   endfunction

   // Compares each result beat with the oldest expectation.
   always @(posedge clock) begin
      step_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_steps.size() == 0) begin
            $error("result beat with no command outstanding");
            mismatch_cnt++;
         end else begin
            exp_r = pending_steps.pop_front();
            check_field("pulse", 64'(exp_r.pulse), 64'(rsp_pulse));
            check_field("dir_level", 64'(exp_r.dir_level), 64'(rsp_dir_level));
            check_field("wait_us", 64'(exp_r.wait_us), 64'(rsp_wait_us));
            check_field("position", 64'(exp_r.position), 64'(rsp_position));
            check_field("done_res", 64'(exp_r.done_res), 64'(rsp_done_res));
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("stepper_ramp_step_generator_top test failed");
            $finish;
         end
      end
   end

   // Extreme targets, every command, shared ramp, homing and idle cases.
   task automatic test_directed_cases();
      idle_on = 1'b1;
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_NONE, 1'b1, $urandom(), 1'b1);
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b0, 32'h7FFF_FFFF, 1'b1);
      repeat (4) send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b1, 32'h8000_0000, 1'b0);
      repeat (2) send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b1, $urandom(), 1'b1);
      // The x axis continues the ramp restarted by the y target.
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, 32'h0, 1'b1);
      // Targeting the current position reports done and keeps the delay.
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b0, axis_pos[0], 1'b0);
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_NONE, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b0, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b1, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b0, $urandom(), 1'b1);
      send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b1, $urandom(), 1'b1);
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b1, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b1, 32'd1, 1'b0);
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b1, $urandom(), 1'b0);
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b1, 32'd0, 1'b1);
      send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b1, $urandom(), 1'b0);
   endtask

   // Homing delay register at its extremes and alternating bit patterns.
   task automatic test_home_delay();
      logic [srsg_pkg::DELAY_W-1:0] settings [6];
      settings = '{16'd0, 16'd1, 16'hFFFF, 16'hAAAA, 16'h5555, 16'd150};
      foreach (settings[i]) begin
         write_home_delay(settings[i]);
         send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b0, $urandom(), 1'b0);
         send_cmd(srsg_pkg::CMD_HOME_TICK, 1'b1, $urandom(), 1'b0);
         send_cmd(srsg_pkg::CMD_HOME_TICK, rand_bit(), $urandom(), 1'b1);
      end
   endtask

   // One back-to-back move that climbs well into the ramp table, then a few
   // steps past the target.
   task automatic test_ramp_climb();
      idle_on = 1'b0;
      send_cmd(srsg_pkg::CMD_SET_TARGET, 1'b0, axis_pos[0] + 200, 1'b0);
      repeat (202) send_cmd(srsg_pkg::CMD_MOVE_STEP, 1'b0, $urandom(), rand_bit());
      settle_block();
   endtask

   // Random move and homing sequences with noise and pauses between them.
   task automatic test_random_traffic(input int n_beats, input bit with_gaps);
      int                                stop_at;
      int                                kind;
      int                                offset;
      int                                n_steps;
      int unsigned                       pick;
      logic                              ax;
      logic signed [srsg_pkg::POS_W-1:0] goal;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         idle_on = with_gaps && ($urandom_range(0, 2) != 0);
         // Without gaps, no register writes or pauses are drawn.
         kind    = with_gaps ? $urandom_range(0, 99) : $urandom_range(0, 89);
         ax      = rand_bit();
         if (kind < 50) begin
            // Short move to a nearby target, sometimes stepped past the end.
            offset = $urandom_range(0, 30);
            if ($urandom_range(0, 1)) offset = -offset;
            goal = axis_pos[ax] + offset;
            send_cmd(srsg_pkg::CMD_SET_TARGET, ax, goal, rand_bit());
            n_steps = (offset < 0 ? -offset : offset) + $urandom_range(0, 2);
            repeat (n_steps) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_cmd(srsg_pkg::CMD_MOVE_STEP, ~ax, $urandom(), rand_bit());
               end
               send_cmd(srsg_pkg::CMD_MOVE_STEP, ax, $urandom(), rand_bit());
            end
         end else if (kind < 65) begin
            // Homing: a few ticks away from the sensor, then the sensor hit.
            repeat ($urandom_range(0, 5)) begin
               send_cmd(srsg_pkg::CMD_HOME_TICK, ax, $urandom(), 1'b0);
            end
            send_cmd(srsg_pkg::CMD_HOME_TICK, ax, $urandom(), 1'b1);
         end else if (kind < 75) begin
            // Full-range target with only a few steps toward it.
            send_cmd(srsg_pkg::CMD_SET_TARGET, ax, $urandom(), rand_bit());
            repeat ($urandom_range(1, 3)) begin
               send_cmd(srsg_pkg::CMD_MOVE_STEP, ax, $urandom(), 1'b0);
            end
         end else if (kind < 90) begin
            pick = $urandom();
            send_cmd(pick[srsg_pkg::CMD_W-1:0], ax, $urandom(), rand_bit());
         end else if (kind < 94) begin
            pick = $urandom();
            write_home_delay(pick[srsg_pkg::DELAY_W-1:0]);
         end else begin
            settle_block();
         end
      end
   endtask

   initial begin
      home_delay  = srsg_pkg::HOME_DELAY_RESET;
      axis_pos[0] = '0;
      axis_pos[1] = '0;
      axis_tgt[0] = '0;
      axis_tgt[1] = '0;
      move_cnt    = '0;
      ramp_pos    = 0;
      cur_wait    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_home_delay();
      test_ramp_climb();
      test_random_traffic(180, 1'b1);
      test_random_traffic(100, 1'b0);

      settle_block();
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("stepper_ramp_step_generator_top test passed");
      end else begin
         $display("stepper_ramp_step_generator_top test failed");
      end
      $finish;
   end

endmodule
